// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the current sense filter checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is asserted
`define CSEF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define CSEF_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/csef_pkg.sv =====
// ---------------------------------------------------------------------------
// csef_pkg
// types, constants and helpers of the current sense ema filter
// ---------------------------------------------------------------------------
package csef_pkg;

  localparam int ADC_BITS_DEF        = 12;
  localparam int OVERSAMPLE_LOG2_DEF = 4;

  localparam int SAMPLE_FIELD_W = 12;
  localparam int CAL_LOG2_MAX   = 10;
  localparam int CNT_W          = CAL_LOG2_MAX + 1;
  localparam int CUR_W          = 32;
  localparam int MC_W           = CUR_W + 1;
  localparam int MPL_W          = 24;
  localparam int PROD_W         = MC_W + 1 + MPL_W;
  localparam int ROUND_SHIFT    = 8;
  localparam int ALPHA_FRAC     = 16;

  localparam int APC_W     = 24;
  localparam int ALPHA_W   = 17;
  localparam int LIMIT_W   = 31;
  localparam int CAL_LOG_W = 4;

  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  localparam logic [APC_W-1:0]     APC_RST      = APC_W'(285);
  localparam logic [ALPHA_W-1:0]   ALPHA_RST    = ALPHA_W'(16384);
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE    = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST    = LIMIT_W'(327680);
  localparam logic [CAL_LOG_W-1:0] CAL_LOG2_RST = CAL_LOG_W'(6);

  localparam logic OP_MEAS = 1'b0;
  localparam logic OP_CAL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPS_PER_CODE  = 2'd0,
    REG_EMA_ALPHA      = 2'd1,
    REG_OVC_LIMIT      = 2'd2,
    REG_CAL_COUNT_LOG2 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      op;
    logic [SAMPLE_FIELD_W-1:0] adc_sample;
  } csef_in_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] filtered_current;
    logic                    overcurrent;
    logic                    calibration_done;
  } csef_out_t;

  // clamp a wide signed value to the 32-bit current range
  function automatic logic [CUR_W-1:0] sat_cur(input logic [PROD_W-1:0] x);
    logic [PROD_W-CUR_W:0] top;
    top = x[PROD_W-1:CUR_W-1];
    if (top == '0 || top == '1) begin
      return x[CUR_W-1:0];
    end else if (x[PROD_W-1]) begin
      return {1'b1, {(CUR_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CUR_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== sv/current_sense_ema_filter.sv =====
// ---------------------------------------------------------------------------
// current_sense_ema_filter
// oversampled current sense with zero calibration, gain and ema smoothing
// ---------------------------------------------------------------------------
// channel | ports                                 | direction
// input   | in_valid, in_stall, in_data           | op + adc sample in
// result  | out_valid, out_stall, out_data        | filtered current out
// config  | cfg_wr_en, cfg_index, cfg_wdata       | register writes in
//
// a sample inside a run is accumulated in idle; a calibration run end passes fin
// and out, a measurement run end fin, mul1, inst, then mul2 and ema once primed,
// then flag and out: one shared shift-add multiplier retires one multiplier bit
// per cycle, once for the gain and, once primed, for the filter weight
// reset is synchronous; registers and filter state return to defaults
// in_stall is high while a run end is in work; a full result register
// holds the next result back but not the samples inside a run
// ---------------------------------------------------------------------------
module current_sense_ema_filter #(
  parameter int ADC_BITS        = csef_pkg::ADC_BITS_DEF,
  parameter int OVERSAMPLE_LOG2 = csef_pkg::OVERSAMPLE_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  csef_pkg::csef_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output csef_pkg::csef_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [csef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csef_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import csef_pkg::*;

  localparam int SUM_W   = ADC_BITS + CAL_LOG2_MAX;
  localparam int SCL_W   = SUM_W + ROUND_SHIFT;
  localparam int AVG_W   = (SCL_W > CUR_W) ? CUR_W : SCL_W;
  localparam int HI_W    = MC_W + 1;
  localparam int MCNT_W  = $clog2(MPL_W);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_FIN  = 8'b0000_0010,
    ST_MUL1 = 8'b0000_0100,
    ST_INST = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_EMA  = 8'b0010_0000,
    ST_FLAG = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [APC_W-1:0]        apc_r, apc_nxt;
  logic [ALPHA_W-1:0]      alpha_r, alpha_nxt;
  logic [LIMIT_W-1:0]      limit_r, limit_nxt;
  logic [CAL_LOG_W-1:0]    cal_log2_r, cal_log2_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    run_kind_r, run_kind_nxt;
  logic [AVG_W-1:0]        zo_r, zo_nxt;
  logic [AVG_W-1:0]        avg_r, avg_nxt;
  logic [CUR_W-1:0]        filt_r, filt_nxt;
  logic                    primed_r, primed_nxt;
  logic [MC_W-1:0]         mc_r, mc_nxt;
  logic [HI_W-1:0]         hi_r, hi_nxt;
  logic [MPL_W-1:0]        lo_r, lo_nxt;
  logic [MCNT_W-1:0]       mcnt_r, mcnt_nxt;
  csef_out_t               res_r, res_nxt;
  csef_out_t               out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // sample intake
  logic [SAMPLE_FIELD_W+ADC_BITS-1:0] sample_ext;
  logic [ADC_BITS-1:0]     sample;
  logic                    in_xfer;
  logic                    new_run;
  logic [SUM_W-1:0]        sum_new;
  logic [CNT_W-1:0]        cnt_new;
  logic [CAL_LOG_W-1:0]    cal_eff;
  logic [CAL_LOG_W-1:0]    run_log2;
  logic [CNT_W-1:0]        run_len;
  logic                    run_done;
  logic [SCL_W-1:0]        scaled;

  // arithmetic
  logic [AVG_W:0]          diff;
  logic [HI_W-1:0]         mul_sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_shr8;
  logic signed [PROD_W-1:0] prod_shr16;
  logic [PROD_W-1:0]       inst_w;
  logic [CUR_W-1:0]        inst;
  logic [MC_W-1:0]         ema_d;
  logic [PROD_W-1:0]       ema_w;
  logic [ALPHA_W-1:0]      alpha_eff;
  logic [CUR_W:0]          filt_ext;
  logic [CUR_W:0]          mag;
  logic                    ovc;

  assign sample_ext = {{ADC_BITS{1'b0}}, in_data.adc_sample};
  assign sample     = sample_ext[ADC_BITS-1:0];
  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && (state_r == ST_IDLE);

  assign new_run  = (in_data.op != run_kind_r);
  assign sum_new  = (new_run ? '0 : sum_r) + SUM_W'(sample);
  assign cnt_new  = (new_run ? '0 : cnt_r) + CNT_W'(1);
  assign cal_eff  = (cal_log2_r > CAL_LOG_W'(CAL_LOG2_MAX)) ? CAL_LOG_W'(CAL_LOG2_MAX)
                                                            : cal_log2_r;
  assign run_log2 = (in_data.op == OP_CAL) ? cal_eff : CAL_LOG_W'(OVERSAMPLE_LOG2);
  assign run_len  = CNT_W'(1) << run_log2;
  assign run_done = (cnt_new >= run_len);
  assign scaled   = {sum_new, {ROUND_SHIFT{1'b0}}} >> run_log2;

  assign diff = {1'b0, avg_r} - {1'b0, zo_r};

  // shift-add step: signed multiplicand, unsigned multiplier, lsb first
  assign mul_sum = lo_r[0] ? (hi_r + {mc_r[MC_W-1], mc_r}) : hi_r;
  assign prod    = $signed({hi_r, lo_r});

  // floor((p + half) / 2^n) is floor(p / 2^n) plus the bit below the cut
  assign prod_shr8  = prod >>> ROUND_SHIFT;
  assign prod_shr16 = prod >>> ALPHA_FRAC;
  assign inst_w     = prod_shr8 + PROD_W'(prod[ROUND_SHIFT-1]);
  assign inst       = sat_cur(inst_w);
  assign ema_d      = {inst[CUR_W-1], inst} - {filt_r[CUR_W-1], filt_r};
  assign ema_w      = prod_shr16 + PROD_W'(prod[ALPHA_FRAC-1])
                      + {{(PROD_W-CUR_W){filt_r[CUR_W-1]}}, filt_r};
  assign alpha_eff  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  assign filt_ext = {filt_r[CUR_W-1], filt_r};
  assign mag      = filt_r[CUR_W-1] ? ((CUR_W+1)'(0) - filt_ext) : filt_ext;
  assign ovc      = (mag > {2'b00, limit_r});

  always_comb begin
    state_nxt     = state_r;
    apc_nxt       = apc_r;
    alpha_nxt     = alpha_r;
    limit_nxt     = limit_r;
    cal_log2_nxt  = cal_log2_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    run_kind_nxt  = run_kind_r;
    zo_nxt        = zo_r;
    avg_nxt       = avg_r;
    filt_nxt      = filt_r;
    primed_nxt    = primed_r;
    mc_nxt        = mc_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mcnt_nxt      = mcnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_AMPS_PER_CODE:  apc_nxt      = cfg_wdata[APC_W-1:0];
        REG_EMA_ALPHA:      alpha_nxt    = cfg_wdata[ALPHA_W-1:0];
        REG_OVC_LIMIT:      limit_nxt    = cfg_wdata[LIMIT_W-1:0];
        REG_CAL_COUNT_LOG2: cal_log2_nxt = cfg_wdata[CAL_LOG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          run_kind_nxt = in_data.op;
          if (run_done) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            avg_nxt   = scaled[AVG_W-1:0];
            state_nxt = ST_FIN;
          end else begin
            sum_nxt = sum_new;
            cnt_nxt = cnt_new;
          end
        end
      end
      ST_FIN: begin
        if (run_kind_r == OP_CAL) begin
          zo_nxt     = avg_r;
          primed_nxt = 1'b0;
          res_nxt    = '{filtered_current: '0, overcurrent: 1'b0, calibration_done: 1'b1};
          state_nxt  = ST_OUT;
        end else begin
          mc_nxt    = MC_W'($signed(diff));
          hi_nxt    = '0;
          lo_nxt    = MPL_W'(apc_r);
          mcnt_nxt  = '0;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1, ST_MUL2: begin
        hi_nxt   = {mul_sum[HI_W-1], mul_sum[HI_W-1:1]};
        lo_nxt   = {mul_sum[0], lo_r[MPL_W-1:1]};
        mcnt_nxt = mcnt_r + MCNT_W'(1);
        if (mcnt_r == MCNT_W'(MPL_W - 1)) begin
          state_nxt = (state_r == ST_MUL1) ? ST_INST : ST_EMA;
        end
      end
      ST_INST: begin
        if (!primed_r) begin
          filt_nxt   = inst;
          primed_nxt = 1'b1;
          state_nxt  = ST_FLAG;
        end else begin
          mc_nxt    = ema_d;
          hi_nxt    = '0;
          lo_nxt    = MPL_W'(alpha_eff);
          mcnt_nxt  = '0;
          state_nxt = ST_MUL2;
        end
      end
      ST_EMA: begin
        filt_nxt  = sat_cur(ema_w);
        state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        res_nxt   = '{filtered_current: filt_r, overcurrent: ovc, calibration_done: 1'b0};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // result register is free or its transfer completes this cycle
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      apc_r       <= APC_RST;
      alpha_r     <= ALPHA_RST;
      limit_r     <= LIMIT_RST;
      cal_log2_r  <= CAL_LOG2_RST;
      sum_r       <= '0;
      cnt_r       <= '0;
      run_kind_r  <= OP_MEAS;
      zo_r        <= AVG_W'(1) << (ADC_BITS + ROUND_SHIFT - 1);
      filt_r      <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      apc_r       <= apc_nxt;
      alpha_r     <= alpha_nxt;
      limit_r     <= limit_nxt;
      cal_log2_r  <= cal_log2_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      run_kind_r  <= run_kind_nxt;
      zo_r        <= zo_nxt;
      filt_r      <= filt_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r      <= avg_nxt;
    mc_r       <= mc_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    mcnt_r     <= mcnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/csef_checker.sv =====
// ---------------------------------------------------------------------------
// csef_checker
// port-level checks of the current sense ema filter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csef_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input csef_pkg::csef_out_t             out_data
);
  import csef_pkg::*;

  // a stalled result stays put
  `CSEF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // calibration results carry no current and no flag
  `CSEF_ASSERT(a_cal_zero, clk, rst_n, out_valid && out_data.calibration_done |-> out_data.filtered_current == '0 && !out_data.overcurrent, "calibration result carries a current")

  // a flagged current is never zero, the limit being non-negative
  `CSEF_ASSERT(a_ovc_nonzero, clk, rst_n, out_valid && out_data.overcurrent |-> out_data.filtered_current != '0, "overcurrent flagged on zero current")

  // reset empties the result register and reopens the input
  `CSEF_ASSERT_NORST(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "reset left a result or a stall")

endmodule

bind current_sense_ema_filter csef_checker u_csef_checker (.*);

// ===== verif/current_sense_checker.sv =====
// ---------------------------------------------------------------------------
// current_sense_checker
// watches the sample, result and register ports of the current sense filter,
// predicts each filtered reading and calibration end, and compares results
// ---------------------------------------------------------------------------
module current_sense_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  csef_pkg::csef_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  csef_pkg::csef_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [csef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_total,
  output int                              awaited_total,
  output int                              reading_total,
  output int                              cal_total
);
  import csef_pkg::*;

  localparam int     MEAS_LOG2 = OVERSAMPLE_LOG2_DEF;
  localparam longint CUR_MAX   = 64'sd2147483647;
  localparam longint CUR_MIN   = -CUR_MAX - 1;

  // register copies
  logic [APC_W-1:0]     gain;
  logic [ALPHA_W-1:0]   alpha;
  logic [LIMIT_W-1:0]   limit;
  logic [CAL_LOG_W-1:0] cal_log2;

  // accumulation and filter state
  logic [21:0]    acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic           acc_kind;
  // a run cut short by a register change can average above full scale
  logic [31:0]    zero_level;
  longint         ema_value;
  logic           ema_primed;

  csef_out_t awaited_results[$];
  csef_out_t head;

  function automatic longint clamp_current(input longint v);
    if (v > CUR_MAX) return CUR_MAX;
    if (v < CUR_MIN) return CUR_MIN;
    return v;
  endfunction

  task automatic advance_filter(input csef_in_t item);
    int        run_log2;
    longint    avg;
    longint    inst;
    longint    weight;
    longint    step;
    longint    mag;
    csef_out_t r;
    if (item.op != acc_kind) begin
      acc_sum   = '0;
      acc_count = '0;
      acc_kind  = item.op;
    end
    // field is exactly ADC_BITS wide, every bit counts
    acc_sum   = acc_sum + item.adc_sample;
    acc_count = acc_count + 1'b1;
    if (acc_kind == OP_CAL) begin
      run_log2 = (cal_log2 > CAL_LOG2_MAX) ? CAL_LOG2_MAX : int'(cal_log2);
    end else begin
      run_log2 = MEAS_LOG2;
    end
    // a run ends once its count reaches or passes the length now in force
    if (acc_count < (1 << run_log2)) return;
    avg       = (longint'(acc_sum) << 8) >> run_log2;
    acc_sum   = '0;
    acc_count = '0;
    r = '0;
    if (acc_kind == OP_CAL) begin
      zero_level = avg[31:0];
      ema_primed = 1'b0;
      r.calibration_done = 1'b1;
    end else begin
      inst = clamp_current(((avg - longint'(zero_level)) * longint'(gain) + 128) >>> 8);
      if (!ema_primed) begin
        ema_value  = inst;
        ema_primed = 1'b1;
      end else begin
        weight    = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
        step      = ((inst - ema_value) * weight + 32768) >>> ALPHA_FRAC;
        ema_value = clamp_current(ema_value + step);
      end
      mag = (ema_value < 0) ? -ema_value : ema_value;
      r.filtered_current = ema_value[CUR_W-1:0];
      r.overcurrent      = (mag > longint'(limit));
    end
    awaited_results.push_back(r);
  endtask

  task automatic check_field(input string what, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain       = APC_RST;
      alpha      = ALPHA_RST;
      limit      = LIMIT_RST;
      cal_log2   = CAL_LOG2_RST;
      acc_sum    = '0;
      acc_count  = '0;
      acc_kind   = OP_MEAS;
      zero_level = 32'(1 << (ADC_BITS_DEF + 7));
      ema_value  = 0;
      ema_primed = 1'b0;
      awaited_results.delete();
      mismatch_total = 0;
      reading_total  = 0;
      cal_total      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none got current %0d oc %0b cal %0b",
                   $time, out_data.filtered_current, out_data.overcurrent,
                   out_data.calibration_done);
          mismatch_total++;
        end else begin
          head = awaited_results.pop_front();
          check_field("filtered_current", head.filtered_current, out_data.filtered_current);
          check_field("overcurrent", head.overcurrent, out_data.overcurrent);
          check_field("calibration_done", head.calibration_done, out_data.calibration_done);
          if (head.calibration_done) cal_total++;
          else reading_total++;
        end
      end
      if (in_valid && !in_stall) advance_filter(in_data);
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_AMPS_PER_CODE:  gain     = cfg_wdata[APC_W-1:0];
          REG_EMA_ALPHA:      alpha    = cfg_wdata[ALPHA_W-1:0];
          REG_OVC_LIMIT:      limit    = cfg_wdata[LIMIT_W-1:0];
          REG_CAL_COUNT_LOG2: cal_log2 = cfg_wdata[CAL_LOG_W-1:0];
          default: ;
        endcase
      end
    end
    awaited_total = awaited_results.size();
  end

endmodule

// ===== verif/current_sense_ema_filter_test.sv =====
// ---------------------------------------------------------------------------
// current_sense_ema_filter_test
// drives calibration and measurement sample runs through the current sense
// filter under random gaps and result stalls, across many register settings
// ---------------------------------------------------------------------------
module current_sense_ema_filter_test;
  import csef_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 75;
  localparam int OVER_CAL_RUN  = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  csef_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  csef_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_total;
  int awaited_total;
  int reading_total;
  int cal_total;

  logic steady = 1'b0;
  int   cycles = 0;
  int   sample_total = 0;
  int   setting_total = 0;
  int   cur_cal = CAL_LOG2_RST;

  always #6 clk = ~clk;

  current_sense_ema_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  current_sense_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatch_total),
    .awaited_total  (awaited_total),
    .reading_total  (reading_total),
    .cal_total      (cal_total)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 33);
  end

  // one sample transfer; valid stays high afterwards unless a gap follows
  task automatic push_sample(input logic op, input logic [SAMPLE_FIELD_W-1:0] sample);
    if (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, adc_sample: sample};
    do @(posedge clk); while (in_stall);
    sample_total++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_total != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int apc, input int alpha, input int limit, input int cal);
    cfg_write(REG_AMPS_PER_CODE, CFG_DATA_W'(apc));
    cfg_write(REG_EMA_ALPHA, CFG_DATA_W'(alpha));
    cfg_write(REG_OVC_LIMIT, CFG_DATA_W'(limit));
    cfg_write(REG_CAL_COUNT_LOG2, CFG_DATA_W'(cal));
    cur_cal = cal;
    setting_total++;
  endtask

  // mostly near a run level, sometimes rail values or anything
  function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample(input int base);
    int v;
    case ($urandom_range(15))
      0: v = 0;
      1: v = 4095;
      2: v = $urandom_range(4095);
      default: v = base + $urandom_range(64) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_FIELD_W'(v);
  endfunction

  task automatic send_run(input logic op, input int len);
    int base;
    base = $urandom_range(4095);
    repeat (len) push_sample(op, pick_sample(base));
  endtask

  task automatic random_phase(input int budget);
    int n;
    int cal_eff;
    int seg;
    int k;
    n = 0;
    cal_eff = (cur_cal > CAL_LOG2_MAX) ? CAL_LOG2_MAX : cur_cal;
    // long calibration runs happen once per phase only; an over-range length
    // acts as the longest run, so a short calibration stretch never ends there
    if (cur_cal > CAL_LOG2_MAX) send_run(OP_CAL, OVER_CAL_RUN);
    else if (cal_eff >= 5) send_run(OP_CAL, 1 << cal_eff);
    while (n < budget) begin
      seg = $urandom_range(99);
      if (seg < 65 || (seg < 80 && cal_eff >= 5)) begin
        send_run(OP_MEAS, 1 << OVERSAMPLE_LOG2_DEF);
        n += 1 << OVERSAMPLE_LOG2_DEF;
      end else if (seg < 80) begin
        send_run(OP_CAL, 1 << cal_eff);
        n += 1 << cal_eff;
      end else if (seg < 90) begin
        // measurement run broken off by a calibration sample
        k = $urandom_range(1, 15);
        send_run(OP_MEAS, k);
        push_sample(OP_CAL, SAMPLE_FIELD_W'($urandom_range(4095)));
        n += k + 1;
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) push_sample(logic'($urandom_range(1)), SAMPLE_FIELD_W'($urandom_range(4095)));
        n += k;
      end
    end
  endtask

  initial begin
    int apc;
    int alpha;
    int limit;
    int cal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rails, saturation, op change mid-run
    configure(24'hFFFFFF, 65536, 31'h7FFFFFFF, 0);
    push_sample(OP_CAL, 12'hFFF);
    // zero input against full scale offset saturates negative, flagged at max limit
    repeat (16) push_sample(OP_MEAS, 12'h000);
    repeat (3) push_sample(OP_MEAS, 12'h800);
    push_sample(OP_CAL, 12'h000);
    settle();

    // calibration length shortened while a calibration run is partial
    configure(285, 16384, 327680, 3);
    repeat (5) push_sample(OP_CAL, 12'h7FF);
    settle();
    cfg_write(REG_CAL_COUNT_LOG2, CFG_DATA_W'(1));
    cur_cal = 1;
    push_sample(OP_CAL, 12'h801);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 5)
        0: apc = 0;
        1: apc = 24'hFFFFFF;
        2: apc = $urandom_range(24'hFFFFFF);
        3: apc = $urandom_range(2000);
        default: apc = 285;
      endcase
      case (p % 6)
        0: alpha = 0;
        1: alpha = 65536;
        2: alpha = $urandom_range(65537, 131071);
        3: alpha = 131071;
        4: alpha = $urandom_range(65535);
        default: alpha = $urandom_range(65536);
      endcase
      case (p % 4)
        0: limit = 0;
        1: limit = 31'h7FFFFFFF;
        2: limit = $urandom & 32'h7FFFFFFF;
        default: limit = $urandom_range(1 << 22);
      endcase
      if (p == 3) cal = CAL_LOG2_MAX - 3;
      else if (p == 8) cal = $urandom_range(11, 15);
      else cal = $urandom_range(4);
      configure(apc, alpha, limit, cal);
      steady <= (p == 5 || p == 6);
      random_phase(PHASE_ITEMS);
      settle();
    end

    $display("sent %0d samples over %0d register settings", sample_total, setting_total);
    $display("checked %0d filtered readings and %0d calibration ends",
             reading_total, cal_total);
    if (mismatch_total == 0 && awaited_total == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
